// ===== hdl/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the text tokenizer: token kinds, lexer
// modes, character codes and the token/entry records passed between parts.
// ----------------------------------------------------------------------------
package ttt_pkg;

    // Default widths and depths
    localparam int POS_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Token kinds
    localparam logic [2:0] KIND_COMMENT  = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_STRING   = 3'd2;
    localparam logic [2:0] KIND_NUMBER   = 3'd3;
    localparam logic [2:0] KIND_OPERATOR = 3'd4;
    localparam logic [2:0] KIND_END      = 3'd5;

    // Lexer modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_STRING  = 3'd4;
    localparam logic [2:0] MODE_IDENT   = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One emitted token, fields already saturated to the output width
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
    } t_token;

    // Tokens caused by one byte: count 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_entry;

endpackage

// ===== hdl/triple_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// triple_text_tokenizer_core
// Streaming text tokenizer: one byte per cycle in while not full, tokens
// out through a queue-style interface.
// A byte's first token passes through the queue and then the output
// register, which loads when it is free or being taken.
// Throughput: one byte per cycle while not full; output drains one token
// per cycle while popped, so a byte causing two tokens is absorbed by the
// QUEUE_DEPTH-entry queue between lexer and output register.
// Reset: synchronous, active low; returns lexer to between-tokens at offset 0.
// ----------------------------------------------------------------------------
module triple_text_tokenizer_core
    import ttt_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_value_start,
    output logic [15:0] o_value_length,
    output logic [15:0] o_start_line,
    output logic        o_last_of_run
);

    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_in, q_out;
    t_token tok;

    // Front end: lexer
    ttt_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_entry      (q_in)
    );

    assign full = q_full;

    // Queue between the two halves
    ttt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    // Back end: token output
    ttt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_tok     (tok),
        .o_last    (o_last_of_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_value_start  = tok.start;
    assign o_value_length = tok.length;
    assign o_start_line   = tok.line;

endmodule

// ===== hdl/ttt_front.sv =====
// ----------------------------------------------------------------------------
// ttt_front
// Lexer front end: takes one byte per cycle while the queue is not full,
// tracks mode, position and line, and pushes the tokens each byte causes
// into the queue as one entry.
module ttt_front
    import ttt_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [7:0]   i_text_byte,
    input  logic         i_end_of_input,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_entry       o_q_entry
);

    localparam int P = POSITION_BITS;

    // Lexer state
    logic [2:0]   r_mode,  n_mode;
    logic [P-1:0] r_pos,   n_pos;
    logic [P-1:0] r_line,  n_line;
    logic [P-1:0] r_begin, n_begin;
    logic [P-1:0] r_bline, n_bline;
    logic         r_bs,    n_bs;

    logic [P-1:0] pos_inc, line_inc;
    logic [P:0]   open_len, cmt_len;
    logic         eof, accept;
    logic         b_op, b_dig, b_ws, b_nl;
    t_token       open_tok, op_tok, end_tok;
    t_entry       ent;

    // begin-token decode
    logic [2:0]   bt_mode;
    logic [P-1:0] bt_begin;
    logic         bt_op;

    function automatic logic [15:0] sat16(input logic [32:0] v);
        logic [15:0] res;
        res = (v > 33'd65535) ? 16'hFFFF : v[15:0];
        return res;
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        logic res;
        res = (b == CH_SEMI) || (b == CH_COMMA) || (b == CH_DOT) ||
              (b == CH_LBRACK) || (b == CH_RBRACK) ||
              (b == CH_LBRACE) || (b == CH_RBRACE);
        return res;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        logic res;
        res = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) ||
              (b == CH_CR) || (b == CH_VT) || (b == CH_FF);
        return res;
    endfunction

    // Classify the byte and prepare counters
    always_comb begin
        b_op  = is_op(i_text_byte);
        b_ws  = is_ws(i_text_byte);
        b_dig = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        b_nl  = (i_text_byte == CH_NL);
        eof   = i_end_of_input || (i_text_byte == CH_NUL);

        pos_inc  = (r_pos  == {P{1'b1}}) ? r_pos  : r_pos  + P'(1);
        line_inc = (r_line == {P{1'b1}}) ? r_line : r_line + P'(1);

        open_len = (r_pos >= r_begin) ? ({1'b0, r_pos} - {1'b0, r_begin}) : '0;
        cmt_len  = (r_pos >= r_begin) ? (open_len + (P+1)'(1)) : '0;

        open_tok.kind   = KIND_IDENT;
        open_tok.start  = sat16(33'(r_begin));
        open_tok.length = sat16(33'(open_len));
        open_tok.line   = sat16(33'(r_bline));

        op_tok.kind     = KIND_OPERATOR;
        op_tok.start    = sat16(33'(r_pos));
        op_tok.length   = 16'd1;
        op_tok.line     = sat16(33'(r_line));

        end_tok.kind    = KIND_END;
        end_tok.start   = sat16(33'(r_pos));
        end_tok.length  = 16'd0;
        end_tok.line    = sat16(33'(r_line));
    end

    // Decode how this byte would open a new token
    always_comb begin
        bt_begin = r_pos;
        bt_op    = 1'b0;
        if (b_ws) begin
            bt_mode = MODE_IDLE;
        end else if (i_text_byte == CH_SLASH) begin
            bt_mode = MODE_SLASH;
        end else if (b_dig) begin
            bt_mode = MODE_NUMBER;
        end else if (i_text_byte == CH_QUOTE) begin
            bt_mode  = MODE_STRING;
            bt_begin = pos_inc;
        end else if (b_op) begin
            bt_mode = MODE_IDLE;
            bt_op   = 1'b1;
        end else begin
            bt_mode = MODE_IDENT;
        end
    end

    // Lexer step: next state and tokens emitted
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_line  = r_line;
        n_begin = r_begin;
        n_bline = r_bline;
        n_bs    = r_bs;
        ent     = '0;

        if (eof) begin
            // flush the open token, then the end token
            unique case (r_mode)
                MODE_SLASH: begin
                    ent.cnt         = 2'd1;
                    ent.tok0        = open_tok;
                    ent.tok0.length = 16'd1;
                end
                MODE_COMMENT: begin
                    ent.cnt       = 2'd1;
                    ent.tok0      = open_tok;
                    ent.tok0.kind = KIND_COMMENT;
                end
                MODE_NUMBER: begin
                    ent.cnt       = 2'd1;
                    ent.tok0      = open_tok;
                    ent.tok0.kind = KIND_NUMBER;
                end
                MODE_STRING: begin
                    ent.cnt       = 2'd1;
                    ent.tok0      = open_tok;
                    ent.tok0.kind = KIND_STRING;
                end
                MODE_IDENT: begin
                    ent.cnt  = 2'd1;
                    ent.tok0 = open_tok;
                end
                default: begin
                    ent.cnt = 2'd0;
                end
            endcase
            if (ent.cnt == 2'd1) begin
                ent.tok1 = end_tok;
                ent.cnt  = 2'd2;
            end else begin
                ent.tok0 = end_tok;
                ent.cnt  = 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_line  = '0;
            n_begin = '0;
            n_bline = '0;
            n_bs    = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_SLASH, MODE_IDENT: begin
                    if ((r_mode == MODE_SLASH) && (i_text_byte == CH_SLASH)) begin
                        n_begin = pos_inc;
                        n_mode  = MODE_COMMENT;
                    end else if (b_op) begin
                        ent.cnt  = 2'd2;
                        ent.tok0 = open_tok;
                        ent.tok1 = op_tok;
                        n_mode   = MODE_IDLE;
                    end else if (b_ws) begin
                        ent.cnt  = 2'd1;
                        ent.tok0 = open_tok;
                        n_mode   = MODE_IDLE;
                    end else begin
                        n_mode = MODE_IDENT;
                    end
                end
                MODE_COMMENT: begin
                    if (b_nl) begin
                        ent.cnt         = 2'd1;
                        ent.tok0        = open_tok;
                        ent.tok0.kind   = KIND_COMMENT;
                        ent.tok0.length = sat16(33'(cmt_len));
                        n_mode          = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (!b_dig) begin
                        ent.cnt       = 2'd1;
                        ent.tok0      = open_tok;
                        ent.tok0.kind = KIND_NUMBER;
                        n_mode        = bt_mode;
                        n_begin       = bt_begin;
                        n_bline       = r_line;
                        if (i_text_byte == CH_QUOTE) begin
                            n_bs = 1'b0;
                        end
                        if (bt_op) begin
                            ent.cnt  = 2'd2;
                            ent.tok1 = op_tok;
                        end
                    end
                end
                MODE_STRING: begin
                    if ((i_text_byte == CH_QUOTE) && !r_bs) begin
                        ent.cnt       = 2'd1;
                        ent.tok0      = open_tok;
                        ent.tok0.kind = KIND_STRING;
                        n_mode        = MODE_IDLE;
                    end
                    n_bs = (i_text_byte == CH_BSLASH);
                end
                default: begin
                    n_mode  = bt_mode;
                    n_begin = bt_begin;
                    n_bline = r_line;
                    if (i_text_byte == CH_QUOTE) begin
                        n_bs = 1'b0;
                    end
                    if (bt_op) begin
                        ent.cnt  = 2'd1;
                        ent.tok0 = op_tok;
                    end
                end
            endcase
            if (b_nl) begin
                n_line = line_inc;
            end
            n_pos = pos_inc;
        end
    end

    assign accept    = i_push && !i_q_full;
    assign o_q_push  = accept && (ent.cnt != 2'd0);
    assign o_q_entry = ent;

    // Advance lexer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_line  <= '0;
            r_begin <= '0;
            r_bline <= '0;
            r_bs    <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_begin <= n_begin;
            r_bline <= n_bline;
            r_bs    <= n_bs;
        end
    end

endmodule

// ===== hdl/ttt_fifo.sv =====
// ----------------------------------------------------------------------------
// ttt_fifo
// Short queue of token entries between the lexer front end and the output
// stage, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ttt_fifo
    import ttt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/ttt_back.sv =====
// ----------------------------------------------------------------------------
// ttt_back
// Output stage: takes entries from the queue and presents their tokens one
// at a time in an output register, marking the last token of each byte.
// ----------------------------------------------------------------------------
module ttt_back
    import ttt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_empty,
    input  t_entry i_q_entry,
    output logic   o_q_pop,
    input  logic   i_pop,
    output logic   o_empty,
    output t_token o_tok,
    output logic   o_last
);

    logic   r_valid;
    logic   r_pend;
    logic   r_last;
    t_token r_tok;
    t_token r_ptok;
    logic   load;

    // Refill the output register when it is free or being taken
    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !r_pend && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q_empty) begin
                r_valid <= 1'b1;
                r_pend  <= (i_q_entry.cnt == 2'd2);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the second token until the first is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_tok  <= r_ptok;
                r_last <= 1'b1;
            end else if (!i_q_empty) begin
                r_tok  <= i_q_entry.tok0;
                r_last <= (i_q_entry.cnt != 2'd2);
                r_ptok <= i_q_entry.tok1;
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triple_text_tokenizer_core. A lexer model inside
// the bench predicts the tokens of plain byte items; typed rows carry
// theirs written by hand. Stimulus is a short directed text, then random
// token text with cuts at random points. Both sides of the queue interface
// gap at random; one long pop stall fills the block until it refuses items.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttt_pkg::*;

    localparam int POS_MAX      = (1 << POS_BITS_DEF) - 1;
    localparam int OUT_MAX      = 65535;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DIR_ROWS     = 28;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_exp_tok;

    // One byte item; typed rows carry their tokens written out by hand
    typedef struct packed {
        logic [7:0] chr;
        logic       eoi;
        logic       typed;
        logic [1:0] n;
        t_exp_tok   t0;
        t_exp_tok   t1;
    } t_text_item;

    localparam t_exp_tok NO_TOK = '0;

    function automatic t_exp_tok tk(logic [2:0] k, int s, int l, int ln, logic last);
        return '{k, 16'(s), 16'(l), 16'(ln), last};
    endfunction

    function automatic t_text_item row(logic [7:0] c, logic e, logic [1:0] n,
                                       t_exp_tok a, t_exp_tok b);
        return '{c, e, 1'b1, n, a, b};
    endfunction

    function automatic t_text_item plain(logic [7:0] c, logic e);
        return '{c, e, 1'b0, 2'd0, NO_TOK, NO_TOK};
    endfunction

    // Directed text: operator, comment, escaped string, number then operator,
    // slash turning into identifier, open tokens cut by end of input
    localparam t_text_item DIR_TAB [DIR_ROWS] = '{
        row(CH_DOT, 1'b0, 2'd1, tk(KIND_OPERATOR, 0, 1, 0, 1'b1), NO_TOK),
        row(CH_SLASH, 1'b0, 2'd0, NO_TOK, NO_TOK),
        row(CH_SLASH, 1'b0, 2'd0, NO_TOK, NO_TOK),
        row("x", 1'b0, 2'd0, NO_TOK, NO_TOK),
        row(CH_NL, 1'b0, 2'd1, tk(KIND_COMMENT, 3, 2, 0, 1'b1), NO_TOK),
        plain(CH_QUOTE, 1'b0),
        plain(CH_BSLASH, 1'b0),
        plain(CH_QUOTE, 1'b0),
        row(CH_QUOTE, 1'b0, 2'd1, tk(KIND_STRING, 6, 2, 1, 1'b1), NO_TOK),
        plain(CH_NINE, 1'b0),
        plain(CH_ZERO, 1'b0),
        row(CH_RBRACE, 1'b0, 2'd2, tk(KIND_NUMBER, 9, 2, 1, 1'b0),
            tk(KIND_OPERATOR, 11, 1, 1, 1'b1)),
        plain(CH_SLASH, 1'b0),
        plain(8'hFF, 1'b0),
        plain(CH_LBRACK, 1'b0),
        plain(CH_SLASH, 1'b0),
        plain(CH_SPACE, 1'b0),
        plain(8'h80, 1'b0),
        plain(8'h41, 1'b1),
        plain(CH_QUOTE, 1'b0),
        plain("q", 1'b0),
        row(CH_NUL, 1'b0, 2'd2, tk(KIND_STRING, 1, 1, 0, 1'b0),
            tk(KIND_END, 2, 0, 0, 1'b1)),
        plain(CH_TAB, 1'b0),
        plain("7", 1'b0),
        plain(8'h7F, 1'b1),
        plain(CH_SLASH, 1'b0),
        row(CH_NUL, 1'b1, 2'd2, tk(KIND_IDENT, 0, 1, 0, 1'b0),
            tk(KIND_END, 1, 0, 0, 1'b1)),
        row(CH_SEMI, 1'b1, 2'd1, tk(KIND_END, 0, 0, 0, 1'b1), NO_TOK)
    };

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    t_text_item  cur_item  = '0;
    wire  [7:0]  i_text_byte    = cur_item.chr;
    wire         i_end_of_input = cur_item.eoi;
    logic        full;
    logic        empty;
    logic [2:0]  o_token_kind;
    logic [15:0] o_value_start;
    logic [15:0] o_value_length;
    logic [15:0] o_start_line;
    logic        o_last_of_run;

    bit          in_random   = 1'b0;
    bit          calm        = 1'b0;
    bit          hold_armed  = 1'b1;
    bit          allow_cuts  = 1'b0;
    int          hold_left   = 0;
    int          cycle_count = 0;
    int          err_count   = 0;

    t_text_item  text_q[$];
    t_exp_tok    due_tokens[$];

    triple_text_tokenizer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_value_start  (o_value_start),
        .o_value_length (o_value_length),
        .o_start_line   (o_start_line),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    logic [2:0] lx_mode   = MODE_IDLE;
    int         lx_pos    = 0;
    int         lx_line   = 0;
    int         tok_begin = 0;
    int         tok_line  = 0;
    bit         after_bslash = 1'b0;
    t_exp_tok   step_tok [2];
    int         step_n;

    function automatic int sat_inc(int v);
        return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function automatic logic [15:0] clip16(int v);
        return (v > OUT_MAX) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit is_op(logic [7:0] b);
        return b == CH_SEMI || b == CH_COMMA || b == CH_DOT || b == CH_LBRACK ||
               b == CH_RBRACK || b == CH_LBRACE || b == CH_RBRACE;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR ||
               b == CH_VT || b == CH_FF;
    endfunction

    function void lex_reset();
        lx_mode      = MODE_IDLE;
        lx_pos       = 0;
        lx_line      = 0;
        tok_begin    = 0;
        tok_line     = 0;
        after_bslash = 1'b0;
    endfunction

    // Append one token of this byte; at most two per byte
    function void put_tok(logic [2:0] kind, int start, int len, int ln);
        if (step_n < 2) begin
            step_tok[step_n] = '{kind, clip16(start), clip16(len), clip16(ln), 1'b0};
            step_n++;
        end
    endfunction

    function void open_tok(logic [2:0] kind);
        put_tok(kind, tok_begin, (lx_pos >= tok_begin) ? lx_pos - tok_begin : 0,
                tok_line);
    endfunction

    function void start_tok(logic [7:0] b);
        tok_begin = lx_pos;
        tok_line  = lx_line;
        if (is_ws(b)) begin
            lx_mode = MODE_IDLE;
        end else if (b == CH_SLASH) begin
            lx_mode = MODE_SLASH;
        end else if (is_digit(b)) begin
            lx_mode = MODE_NUMBER;
        end else if (b == CH_QUOTE) begin
            // value starts after the opening quote
            tok_begin    = sat_inc(lx_pos);
            after_bslash = 1'b0;
            lx_mode      = MODE_STRING;
        end else if (is_op(b)) begin
            put_tok(KIND_OPERATOR, lx_pos, 1, lx_line);
            lx_mode = MODE_IDLE;
        end else begin
            lx_mode = MODE_IDENT;
        end
    endfunction

    function void ident_byte(logic [7:0] b);
        if (is_op(b)) begin
            open_tok(KIND_IDENT);
            put_tok(KIND_OPERATOR, lx_pos, 1, lx_line);
            lx_mode = MODE_IDLE;
        end else if (is_ws(b)) begin
            open_tok(KIND_IDENT);
            lx_mode = MODE_IDLE;
        end
    endfunction

    function void lex_step(logic [7:0] b, logic eoi);
        step_n = 0;
        if (eoi || b == CH_NUL) begin
            // flush the open token, then close the text
            case (lx_mode)
                MODE_SLASH:   put_tok(KIND_IDENT, tok_begin, 1, tok_line);
                MODE_COMMENT: open_tok(KIND_COMMENT);
                MODE_NUMBER:  open_tok(KIND_NUMBER);
                MODE_STRING:  open_tok(KIND_STRING);
                MODE_IDENT:   open_tok(KIND_IDENT);
                default:      ;
            endcase
            put_tok(KIND_END, lx_pos, 0, lx_line);
            lex_reset();
        end else begin
            case (lx_mode)
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        tok_begin = sat_inc(lx_pos);
                        lx_mode   = MODE_COMMENT;
                    end else begin
                        lx_mode = MODE_IDENT;
                        ident_byte(b);
                    end
                end
                MODE_COMMENT: begin
                    // the closing newline counts as part of the value
                    if (b == CH_NL) begin
                        put_tok(KIND_COMMENT, tok_begin,
                                (lx_pos >= tok_begin) ? lx_pos - tok_begin + 1 : 0,
                                tok_line);
                        lx_mode = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(b)) begin
                        open_tok(KIND_NUMBER);
                        start_tok(b);
                    end
                end
                MODE_STRING: begin
                    if (b == CH_QUOTE && !after_bslash) begin
                        open_tok(KIND_STRING);
                        lx_mode = MODE_IDLE;
                    end
                    after_bslash = (b == CH_BSLASH);
                end
                MODE_IDENT: ident_byte(b);
                default:    start_tok(b);
            endcase
            if (b == CH_NL)
                lx_line = sat_inc(lx_line);
            lx_pos = sat_inc(lx_pos);
        end
        if (step_n > 0)
            step_tok[step_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("%0t: tokenizer %s mismatch, got %0d, want %0d",
                 $realtime, what, got, want);
    endtask

    // Predict on each accepted item, then compare each accepted token
    always @(posedge i_clk) begin : check_tokens
        t_exp_tok want;
        if (i_rst_n && push && !full) begin
            lex_step(cur_item.chr, cur_item.eoi);
            if (cur_item.typed) begin
                if (cur_item.n > 0) due_tokens.push_back(cur_item.t0);
                if (cur_item.n > 1) due_tokens.push_back(cur_item.t1);
            end else begin
                for (int k = 0; k < step_n; k++)
                    due_tokens.push_back(step_tok[k]);
            end
        end
        if (i_rst_n && pop && !empty) begin
            if (due_tokens.size() == 0) begin
                report_mismatch("unexpected token kind", o_token_kind, -1);
            end else begin
                want = due_tokens.pop_front();
                if (o_token_kind != want.kind)
                    report_mismatch("kind", o_token_kind, want.kind);
                if (o_value_start != want.start)
                    report_mismatch("value start", o_value_start, want.start);
                if (o_value_length != want.length)
                    report_mismatch("value length", o_value_length, want.length);
                if (o_start_line != want.line)
                    report_mismatch("start line", o_start_line, want.line);
                if (o_last_of_run != want.last)
                    report_mismatch("last of run", o_last_of_run, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random pop gaps, one long hold once random text starts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_armed && in_random) begin
            pop        <= 1'b0;
            hold_armed <= 1'b0;
            hold_left  <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Offer one item until accepted, with random gaps
    task automatic send_item(t_text_item it);
        bit done;
        done = 1'b0;
        while (!done) begin
            if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge i_clk);
            end else begin
                push     <= 1'b1;
                cur_item <= it;
                @(posedge i_clk);
                done = !full;
            end
        end
    endtask

    function void add_end();
        if ($urandom_range(0, 1) == 0)
            text_q.push_back(plain(8'($urandom_range(0, 255)), 1'b1));
        else
            text_q.push_back(plain(CH_NUL, 1'b0));
    endfunction

    // Append a text byte; now and then cut the text just before it
    function void add_byte(logic [7:0] c);
        if (allow_cuts && $urandom_range(0, 79) == 0)
            add_end();
        text_q.push_back(plain(c, 1'b0));
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 6))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 6))
            0:       return CH_SEMI;
            1:       return CH_COMMA;
            2:       return CH_DOT;
            3:       return CH_LBRACK;
            4:       return CH_RBRACK;
            5:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // Byte that opens an identifier
    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (is_ws(c) || is_op(c) || is_digit(c) || c == CH_QUOTE || c == CH_SLASH);
        return c;
    endfunction

    // Byte that continues an identifier
    function automatic logic [7:0] rand_body();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (is_ws(c) || is_op(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_except(logic [7:0] bad);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == bad);
        return c;
    endfunction

    // Append one well-formed token, mostly followed by whitespace
    function void gen_token();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 6);
        if (pick < 25) begin
            add_byte(rand_other());
            for (int k = 1; k < len; k++)
                add_byte(rand_body());
        end else if (pick < 40) begin
            for (int k = 0; k < len; k++)
                add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end else if (pick < 55) begin
            add_byte(CH_QUOTE);
            for (int k = 1; k < len; k++)
                case ($urandom_range(0, 5))
                    0: add_byte(CH_BSLASH);
                    1: begin
                        add_byte(CH_BSLASH);
                        add_byte(CH_QUOTE);
                    end
                    default: add_byte(rand_except(CH_QUOTE));
                endcase
            add_byte(CH_QUOTE);
        end else if (pick < 65) begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            for (int k = 1; k < len; k++)
                add_byte(rand_except(CH_NL));
            add_byte(CH_NL);
        end else if (pick < 85) begin
            add_byte(rand_op());
        end else if (pick < 92) begin
            // lone slash: becomes an identifier
            add_byte(CH_SLASH);
            add_byte(rand_except(CH_SLASH));
        end else begin
            add_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 9) < 7)
            for (int k = $urandom_range(1, 3); k > 0; k--)
                add_byte(rand_ws());
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIR_TAB[r]);

        // Random token text, with a stretch of no gaps on either side
        in_random  <= 1'b1;
        allow_cuts = 1'b1;
        while (text_q.size() < RANDOM_ITEMS)
            gen_token();
        add_end();
        for (int k = 0; k < text_q.size(); k++) begin
            calm <= (k >= 400 && k < 650);
            send_item(text_q[k]);
        end
        push <= 1'b0;

        // Drain and settle
        @(posedge i_clk);
        while (due_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_tokens.size() != 0)
            report_mismatch("missing tokens, count", 0, due_tokens.size());
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
